@@ src/dday_pkg.sv @@
// shared types, constants and calendar tables for the date day difference block
package dday_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DIST_W  = 22;
    localparam int NUM_W   = 23;
    localparam int QUO_W   = 8;
    localparam int MOFF_W  = 9;
    localparam int PROD_W  = 27;

    // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for every 14-bit x
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int CENTURY     = 100;
    localparam int DAYS_YEAR   = 365;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef logic [YEAR_W-1:0]  t_year;
    typedef logic [MONTH_W-1:0] t_month;
    typedef logic [DAY_W-1:0]   t_day;
    typedef logic [DIST_W-1:0]  t_dist;
    typedef logic [NUM_W-1:0]   t_num;

    localparam t_month JAN = 4'd1;
    localparam t_month FEB = 4'd2;
    localparam t_month MAR = 4'd3;
    localparam t_month APR = 4'd4;
    localparam t_month MAY = 4'd5;
    localparam t_month JUN = 4'd6;
    localparam t_month JUL = 4'd7;
    localparam t_month AUG = 4'd8;
    localparam t_month SEP = 4'd9;
    localparam t_month OCT = 4'd10;
    localparam t_month NOV = 4'd11;
    localparam t_month DEC = 4'd12;

    // length of a month, zero for a month code outside 1..12
    function automatic t_day month_len(input t_month m, input logic leap);
        t_day len;
        case (m)
            FEB:                     len = leap ? 5'd29 : 5'd28;
            APR, JUN, SEP, NOV:      len = 5'd30;
            JAN, MAR, MAY, JUL,
            AUG, OCT, DEC:           len = 5'd31;
            default:                 len = 5'd0;
        endcase
        return len;
    endfunction

    // days of the earlier months of a common year
    function automatic logic [MOFF_W-1:0] month_start(input t_month m);
        logic [MOFF_W-1:0] ofs;
        case (m)
            JAN:     ofs = 9'd0;
            FEB:     ofs = 9'd31;
            MAR:     ofs = 9'd59;
            APR:     ofs = 9'd90;
            MAY:     ofs = 9'd120;
            JUN:     ofs = 9'd151;
            JUL:     ofs = 9'd181;
            AUG:     ofs = 9'd212;
            SEP:     ofs = 9'd243;
            OCT:     ofs = 9'd273;
            NOV:     ofs = 9'd304;
            DEC:     ofs = 9'd334;
            default: ofs = 9'd0;
        endcase
        return ofs;
    endfunction

endpackage

@@ src/date_day_difference.sv @@
// top level: absolute day distance between two gregorian dates
//
// usage
//   a transfer into the block happens at a rising edge with start high and
//   busy low; busy is held low, so a new date pair may be sent every cycle
//   each date pair gives exactly one result: o_valid is high for one cycle
//   with o_day_distance, o_first_valid and o_second_valid
//   the result passes through three day-number stages plus the difference
//   register before it is presented
//   throughput: one date pair per cycle, set by the four register stages
//   a date is valid when its month is 1..12 and its day is 1..month length;
//   the year never makes a date invalid, year 0 counts as a leap year
//   distance is zero when either date is invalid and saturates at the
//   22-bit maximum
//   reset (synchronous, active low) clears the valid pipeline, so pairs in
//   flight are dropped and o_valid is low in the cycle after reset
//   the receiver cannot stall: a result is taken at the edge ending its cycle
module date_day_difference (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  dday_pkg::t_year  i_year_a,
    input  dday_pkg::t_month i_month_a,
    input  dday_pkg::t_day   i_day_a,
    input  dday_pkg::t_year  i_year_b,
    input  dday_pkg::t_month i_month_b,
    input  dday_pkg::t_day   i_day_b,
    output logic             o_valid,
    output dday_pkg::t_dist  o_day_distance,
    output logic             o_first_valid,
    output logic             o_second_valid
);
    import dday_pkg::*;

    // never blocks: the pipeline takes a pair every cycle
    assign busy = 1'b0;

    // per-date day numbers, registered at the last stage of each dday_date_num
    t_num num_a;
    t_num num_b;
    logic ok_a;
    logic ok_b;

    dday_date_num u_date_a (
        .i_clk     (i_clk),
        .i_year    (i_year_a),
        .i_month   (i_month_a),
        .i_day     (i_day_a),
        .o_num     (num_a),
        .o_date_ok (ok_a)
    );

    dday_date_num u_date_b (
        .i_clk     (i_clk),
        .i_year    (i_year_b),
        .i_month   (i_month_b),
        .i_day     (i_day_b),
        .o_num     (num_b),
        .o_date_ok (ok_b)
    );

    // valid bits that follow each pair through the four stages
    logic [3:0] r_vld;
    logic [3:0] n_vld;

    assign n_vld = {r_vld[2:0], start & ~busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // stage 4: absolute difference, saturation, zero on an invalid date
    t_num  n_diff;
    t_dist n_dist;

    assign n_diff = (num_a >= num_b) ? (num_a - num_b) : (num_b - num_a);

    always_comb begin
        if (!(ok_a && ok_b)) begin
            n_dist = '0;
        end else if (n_diff > NUM_W'(DIST_MAX)) begin
            n_dist = DIST_MAX;
        end else begin
            n_dist = n_diff[DIST_W-1:0];
        end
    end

    // output registers, payload without reset
    t_dist r_dist;
    logic  r_first_ok;
    logic  r_second_ok;

    always_ff @(posedge i_clk) begin
        r_dist      <= n_dist;
        r_first_ok  <= ok_a;
        r_second_ok <= ok_b;
    end

    assign o_valid        = r_vld[3];
    assign o_day_distance = r_dist;
    assign o_first_valid  = r_first_ok;
    assign o_second_valid = r_second_ok;

endmodule

@@ src/dday_date_num.sv @@
// three-stage pipeline that checks one date and forms its day number
module dday_date_num (
    input  logic            i_clk,
    input  dday_pkg::t_year  i_year,
    input  dday_pkg::t_month i_month,
    input  dday_pkg::t_day   i_day,
    output dday_pkg::t_num   o_num,
    output logic            o_date_ok
);
    import dday_pkg::*;

    // stage 1: elapsed years and quotients by 100
    logic [YEAR_W-1:0] n_years;
    logic [PROD_W-1:0] n_prod_n;
    logic [PROD_W-1:0] n_prod_y;

    t_year             r_s1_year;
    logic [YEAR_W-1:0] r_s1_n;
    logic [QUO_W-1:0]  r_s1_qn;
    logic [QUO_W-1:0]  r_s1_qy;
    t_month            r_s1_month;
    t_day              r_s1_day;

    assign n_years  = (i_year == '0) ? '0 : i_year - 1'b1;
    assign n_prod_n = PROD_W'(n_years) * PROD_W'(RECIP_100);
    assign n_prod_y = PROD_W'(i_year) * PROD_W'(RECIP_100);

    always_ff @(posedge i_clk) begin
        r_s1_year  <= i_year;
        r_s1_n     <= n_years;
        r_s1_qn    <= n_prod_n[RECIP_SHIFT +: QUO_W];
        r_s1_qy    <= n_prod_y[RECIP_SHIFT +: QUO_W];
        r_s1_month <= i_month;
        r_s1_day   <= i_day;
    end

    // stage 2: leap rule, validity, whole-year days and month offset
    logic              n_div100;
    logic              n_leap;
    logic              n_ok;
    t_num              n_base;
    logic [MOFF_W-1:0] n_moff;

    t_num              r_s2_base;
    logic [MOFF_W-1:0] r_s2_moff;
    t_day              r_s2_day;
    logic              r_s2_ok;

    assign n_div100 = ((YEAR_W+1)'(r_s1_qy) * (YEAR_W+1)'(CENTURY)) == (YEAR_W+1)'(r_s1_year);
    assign n_leap   = ((r_s1_year[1:0] == 2'b00) && !n_div100)
                    || (n_div100 && (r_s1_qy[1:0] == 2'b00));
    assign n_ok     = (r_s1_day != '0) && (r_s1_day <= month_len(r_s1_month, n_leap));
    assign n_base   = NUM_W'(r_s1_n) * NUM_W'(DAYS_YEAR) + NUM_W'(r_s1_n >> 2)
                    - NUM_W'(r_s1_qn) + NUM_W'(r_s1_qn >> 2);
    assign n_moff   = month_start(r_s1_month)
                    + MOFF_W'((r_s1_month > FEB) && n_leap);

    always_ff @(posedge i_clk) begin
        r_s2_base <= n_base;
        r_s2_moff <= n_moff;
        r_s2_day  <= r_s1_day;
        r_s2_ok   <= n_ok;
    end

    // stage 3: day number
    t_num r_s3_num;
    logic r_s3_ok;

    always_ff @(posedge i_clk) begin
        r_s3_num <= r_s2_base + NUM_W'(r_s2_moff) + NUM_W'(r_s2_day);
        r_s3_ok  <= r_s2_ok;
    end

    assign o_num     = r_s3_num;
    assign o_date_ok = r_s3_ok;

endmodule

@@ src/dday_checker.sv @@
// port-level checker for the date day difference block, with its bind
module dday_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input dday_pkg::t_year  i_year_a,
    input dday_pkg::t_month i_month_a,
    input dday_pkg::t_day   i_day_a,
    input dday_pkg::t_year  i_year_b,
    input dday_pkg::t_month i_month_b,
    input dday_pkg::t_day   i_day_b,
    input logic             o_valid,
    input dday_pkg::t_dist  o_day_distance,
    input logic             o_first_valid,
    input logic             o_second_valid
);
    import dday_pkg::*;

    // the block never refuses a transfer
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy asserted");

    // every result comes from a start that entered the pipeline
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 4))
        else $error("result without matching transfer");

    // an invalid date forces a zero distance
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !(o_first_valid && o_second_valid)) |-> (o_day_distance == '0))
        else $error("nonzero distance with invalid date");

    // identical dates give a result of zero distance
    a_same_date_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(start && !busy && (i_year_a == i_year_b) && (i_month_a == i_month_b)
               && (i_day_a == i_day_b), 4)
         && $past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3)
         && $past(i_rst_n, 4))
        |-> (o_valid && (o_day_distance == '0)))
        else $error("identical dates not at zero distance");

endmodule

bind date_day_difference dday_checker u_dday_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_year_a       (i_year_a),
    .i_month_a      (i_month_a),
    .i_day_a        (i_day_a),
    .i_year_b       (i_year_b),
    .i_month_b      (i_month_b),
    .i_day_b        (i_day_b),
    .o_valid        (o_valid),
    .o_day_distance (o_day_distance),
    .o_first_valid  (o_first_valid),
    .o_second_valid (o_second_valid)
);

@@ verif/tb_date_day_difference.sv @@
// self-checking testbench for the gregorian date day difference block
module tb_date_day_difference;
    timeunit 1ns;
    timeprecision 1ps;

    import dday_pkg::*;

    // month codes outside the calendar, used to hit the invalid-month path
    localparam t_month MONTH_NONE = 4'd0;
    localparam t_month MONTH_OVER = 4'd13;
    localparam t_month MONTH_TOP  = 4'd15;

    localparam int unsigned YEAR_TOP   = (1 << YEAR_W) - 1;
    // cycles with no transfer on either side before the run is declared hung
    localparam int unsigned IDLE_LIMIT = 2000;
    // settle time after the last result, longer than the pipeline depth
    localparam int unsigned DRAIN_CYCLES = 8;

    // common-year month lengths and day offsets, indexed by month minus one
    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30,
                                                31, 31, 30, 31, 30, 31};
    localparam int unsigned MONTH_OFFSET [12] = '{0, 31, 59, 90, 120, 151,
                                                  181, 212, 243, 273, 304, 334};

    typedef struct packed {
        t_year  year_a;
        t_month month_a;
        t_day   day_a;
        t_year  year_b;
        t_month month_b;
        t_day   day_b;
    } date_pair_t;

    typedef struct packed {
        t_dist distance;
        logic  first_ok;
        logic  second_ok;
    } day_gap_t;

    logic   i_clk   = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start   = 1'b0;
    logic   busy;
    t_year  i_year_a  = '0;
    t_month i_month_a = '0;
    t_day   i_day_a   = '0;
    t_year  i_year_b  = '0;
    t_month i_month_b = '0;
    t_day   i_day_b   = '0;
    logic   o_valid;
    t_dist  o_day_distance;
    logic   o_first_valid;
    logic   o_second_valid;

    date_pair_t  pending_pairs[$];    // date pairs waiting to be sent
    day_gap_t    due_gaps[$];         // predicted results, oldest first
    logic        pair_taken = 1'b0;   // the pair on the ports moved at the last edge
    int unsigned fail_count  = 0;
    int unsigned idle_cycles = 0;
    int unsigned gap_left    = 0;     // idle cycles still owed before the next pair
    int unsigned calm_left   = 0;     // pairs left in a back-to-back stretch

    date_day_difference uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_year_a       (i_year_a),
        .i_month_a      (i_month_a),
        .i_day_a        (i_day_a),
        .i_year_b       (i_year_b),
        .i_month_b      (i_month_b),
        .i_day_b        (i_day_b),
        .o_valid        (o_valid),
        .o_day_distance (o_day_distance),
        .o_first_valid  (o_first_valid),
        .o_second_valid (o_second_valid)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // calendar arithmetic for the predictor
    // ------------------------------------------------------------------

    // multiples of 4 except centuries, plus every multiple of 400 (year 0 too)
    function automatic logic is_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // zero for a month code that is not a calendar month
    function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
        if (m < JAN || m > DEC) begin
            return 0;
        end
        if (m == FEB && is_leap(y)) begin
            return 29;
        end
        return MONTH_DAYS[m - 1];
    endfunction

    // the year is never checked, only month and day
    function automatic logic date_is_valid(input int unsigned y, input int unsigned m,
                                           input int unsigned d);
        return (d >= 1) && (d <= month_length(y, m));
    endfunction

    // day count from the start of year 1; year 0 has no earlier years
    function automatic int unsigned day_ordinal(input int unsigned y, input int unsigned m,
                                                input int unsigned d);
        int unsigned n;
        int unsigned sum;
        n   = (y == 0) ? 0 : y - 1;
        sum = DAYS_YEAR * n + n / 4 - n / 100 + n / 400;
        sum += MONTH_OFFSET[m - 1];
        if (m > FEB && is_leap(y)) begin
            sum += 1;
        end
        return sum + d;
    endfunction

    // expected result of one date pair
    function automatic day_gap_t predict_distance(input date_pair_t p);
        day_gap_t    r;
        int unsigned na;
        int unsigned nb;
        int unsigned span;
        r.first_ok  = date_is_valid(p.year_a, p.month_a, p.day_a);
        r.second_ok = date_is_valid(p.year_b, p.month_b, p.day_b);
        span = 0;
        // an invalid date on either side forces the distance to zero
        if (r.first_ok && r.second_ok) begin
            na   = day_ordinal(p.year_a, p.month_a, p.day_a);
            nb   = day_ordinal(p.year_b, p.month_b, p.day_b);
            span = (na > nb) ? na - nb : nb - na;
            // spans beyond the 22-bit maximum saturate the output field
            if (span > int'(DIST_MAX)) begin
                span = DIST_MAX;
            end
        end
        r.distance = t_dist'(span);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic add_pair(input int unsigned ya, input int unsigned ma, input int unsigned da,
                            input int unsigned yb, input int unsigned mb, input int unsigned db);
        date_pair_t p;
        p.year_a  = t_year'(ya);
        p.month_a = t_month'(ma);
        p.day_a   = t_day'(da);
        p.year_b  = t_year'(yb);
        p.month_b = t_month'(mb);
        p.day_b   = t_day'(db);
        pending_pairs.push_back(p);
    endtask

    // a real calendar date within the given year
    task automatic pick_date(input int unsigned y, output int unsigned m, output int unsigned d);
        m = $urandom_range(JAN, DEC);
        d = $urandom_range(1, month_length(y, m));
    endtask

    // years biased toward the leap-rule corners
    function automatic int unsigned pick_corner_year();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, YEAR_TOP / 400) * 400;
            1:       return $urandom_range(0, YEAR_TOP / 100) * 100;
            2:       return $urandom_range(0, YEAR_TOP / 4) * 4;
            default: return $urandom_range(0, YEAR_TOP);
        endcase
    endfunction

    // edge days of a month: last day, one past it, day 29, first day, zero
    task automatic pick_edge_date(input int unsigned y, output int unsigned m,
                                  output int unsigned d);
        m = $urandom_range(JAN, DEC);
        case ($urandom_range(0, 4))
            0:       d = month_length(y, m);
            1:       d = month_length(y, m) + 1;
            2:       d = 29;
            3:       d = 1;
            default: d = 0;
        endcase
    endtask

    // ------------------------------------------------------------------
    // driver: presents one pair at a time, holds it until the transfer,
    // then waits out a random gap before the next
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        date_pair_t nxt;
        int unsigned roll;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !pair_taken) begin
            // transfer not done yet, keep the pair on the ports
        end else if (gap_left > 0) begin
            gap_left = gap_left - 1;
            start <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
            nxt = pending_pairs.pop_front();
            i_year_a  <= nxt.year_a;
            i_month_a <= nxt.month_a;
            i_day_a   <= nxt.day_a;
            i_year_b  <= nxt.year_b;
            i_month_b <= nxt.month_b;
            i_day_b   <= nxt.day_b;
            start     <= 1'b1;
            // gap after this pair: mostly none or short, a few long,
            // and now and then a long back-to-back stretch
            roll = $urandom_range(0, 99);
            if (calm_left > 0) begin
                calm_left = calm_left - 1;
                gap_left  = 0;
            end else if (roll < 3) begin
                calm_left = $urandom_range(20, 80);
                gap_left  = 0;
            end else if (roll < 50) begin
                gap_left = 0;
            end else if (roll < 85) begin
                gap_left = $urandom_range(1, 3);
            end else if (roll < 97) begin
                gap_left = $urandom_range(4, 10);
            end else begin
                gap_left = $urandom_range(20, 60);
            end
        end else begin
            start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // monitor: records each input transfer as a prediction, checks each
    // result against the oldest prediction, and runs the watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        date_pair_t seen;
        day_gap_t   want;
        logic       took;
        logic       moved;
        took  = i_rst_n && ((start && !busy) === 1'b1);
        moved = 1'b0;
        if (took) begin
            seen.year_a  = i_year_a;
            seen.month_a = i_month_a;
            seen.day_a   = i_day_a;
            seen.year_b  = i_year_b;
            seen.month_b = i_month_b;
            seen.day_b   = i_day_b;
            due_gaps.push_back(predict_distance(seen));
            moved = 1'b1;
        end
        if (i_rst_n && o_valid === 1'b1) begin
            moved = 1'b1;
            if (due_gaps.size() == 0) begin
                $error("result transfer with no pair outstanding: distance %0d", o_day_distance);
                fail_count++;
            end else begin
                want = due_gaps.pop_front();
                if (o_day_distance !== want.distance) begin
                    $error("day_distance: expected %0d, got %0d", want.distance, o_day_distance);
                    fail_count++;
                end
                if (o_first_valid !== want.first_ok) begin
                    $error("first_valid: expected %0b, got %0b", want.first_ok, o_first_valid);
                    fail_count++;
                end
                if (o_second_valid !== want.second_ok) begin
                    $error("second_valid: expected %0b, got %0b", want.second_ok,
                           o_second_valid);
                    fail_count++;
                end
            end
        end else if (i_rst_n && o_valid !== 1'b0) begin
            $error("o_valid: expected 0, got %b", o_valid);
            fail_count++;
        end
        pair_taken <= took;
        // watchdog: consecutive cycles with no transfer at all
        if (moved || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        int unsigned ya;
        int unsigned ma;
        int unsigned da;
        int unsigned yb;
        int unsigned mb;
        int unsigned db;
        int unsigned kind;

        // directed pairs
        add_pair(2000, JAN, 1, 2000, JAN, 1);                 // same date
        add_pair(1, JAN, 1, 9999, DEC, 31);                   // widest intended span
        add_pair(9999, DEC, 31, 1, JAN, 1);                   // same span, reversed
        add_pair(0, JAN, 1, 1, JAN, 1);                       // year zero has no earlier years
        add_pair(0, FEB, 29, 0, MAR, 1);                      // year zero is a leap year
        add_pair(YEAR_TOP, DEC, 31, 0, JAN, 1);               // distance saturates
        add_pair(YEAR_TOP, DEC, 31, YEAR_TOP, JAN, 1);        // top year, within one year
        add_pair(1900, FEB, 29, 1900, MAR, 1);                // century, not leap
        add_pair(2000, FEB, 29, 1999, DEC, 31);               // multiple of 400, leap
        add_pair(2024, FEB, 29, 2023, FEB, 29);               // only second date invalid
        add_pair(2023, FEB, 28, 2023, MAR, 1);                // common-year february end
        add_pair(2024, FEB, 28, 2024, MAR, 1);                // leap-year february end
        add_pair(2021, MONTH_NONE, 10, 2021, MAY, 5);         // month zero
        add_pair(2021, MONTH_OVER, 1, 2021, MAY, 5);          // month just past december
        add_pair(2021, MONTH_TOP, 31, 2021, APR, 31);         // both dates invalid
        add_pair(2021, JUN, 0, 2021, JUN, 30);                // day zero
        add_pair(2021, JUN, 31, 2021, JUL, 31);               // one past a 30-day month
        add_pair(2021, DEC, 31, 2022, JAN, 1);                // year boundary
        add_pair(8191, AUG, 16, 4096, APR, 8);                // single-bit and low-ones bit patterns
        add_pair(10000, JAN, 1, 9999, DEC, 31);               // year above 9999 is counted
        add_pair(2100, MAR, 1, 2400, FEB, 29);                // century leap rules together
        add_pair(0, MONTH_NONE, 0, YEAR_TOP, MONTH_TOP, 31);  // all-zero and all-ones fields

        // random pairs: mostly real dates, some corner dates and raw noise
        repeat (1900) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                ya = $urandom_range(1, 9999);
                yb = $urandom_range(1, 9999);
                pick_date(ya, ma, da);
                pick_date(yb, mb, db);
            end else if (kind < 65) begin
                // nearby dates, often in the same or the next year
                ya = $urandom_range(0, YEAR_TOP);
                yb = (ya + 2 > YEAR_TOP) ? ya : ya + $urandom_range(0, 2);
                pick_date(ya, ma, da);
                pick_date(yb, mb, db);
            end else if (kind < 72) begin
                // full year range, reaches saturation
                ya = $urandom_range(0, YEAR_TOP);
                yb = $urandom_range(0, YEAR_TOP);
                pick_date(ya, ma, da);
                pick_date(yb, mb, db);
            end else if (kind < 85) begin
                ya = pick_corner_year();
                yb = pick_corner_year();
                pick_edge_date(ya, ma, da);
                if ($urandom_range(0, 1)) begin
                    pick_edge_date(yb, mb, db);
                end else begin
                    pick_date(yb, mb, db);
                end
            end else begin
                ya = $urandom_range(0, YEAR_TOP);
                yb = $urandom_range(0, YEAR_TOP);
                ma = $urandom_range(0, MONTH_TOP);
                mb = $urandom_range(0, MONTH_TOP);
                da = $urandom_range(0, 31);
                db = $urandom_range(0, 31);
            end
            // swap sides now and then so either date can be the later one
            if ($urandom_range(0, 1)) begin
                add_pair(ya, ma, da, yb, mb, db);
            end else begin
                add_pair(yb, mb, db, ya, ma, da);
            end
        end

        // synchronous reset held from time zero, released on a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every pair to be sent and every result to arrive
        @(negedge i_clk);
        while (pending_pairs.size() != 0 || start || due_gaps.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (due_gaps.size() != 0) begin
            $error("%0d results never arrived", due_gaps.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/dday_pkg.sv
src/dday_date_num.sv
src/date_day_difference.sv
src/dday_checker.sv
verif/tb_date_day_difference.sv
